FILE: hdl/svpwm_pkg.sv
// shared types, constants and sine table for the space vector pwm duty block
package svpwm_pkg;

    // field widths
    localparam int ANGLE_W    = 16;
    localparam int VOLT_W     = 16;
    localparam int SUPPLY_W   = 15;
    localparam int PERIOD_W   = 16;
    localparam int SECTOR_W   = 3;
    localparam int COMPARE_W  = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // sine table geometry
    localparam int SINE_N     = 200;
    localparam int SINE_LAST  = SINE_N - 1;
    localparam int SINE_IDX_W = 8;
    localparam int SINE_W     = 14;
    localparam int SINE_SCALE = 10000;

    // angle constants
    localparam int TURN    = 1 << ANGLE_W;
    localparam int QUARTER = TURN / 4;

    // time computation constants
    localparam int UREF_W     = 16;
    localparam int UREF_LIMIT = 37814;
    localparam int SQRT3_Q16  = 113512;
    localparam int TIME_W     = 17;
    localparam int DUTY_W     = 17;
    // exact reciprocal of 10000 for dividends below 2^30
    localparam logic [63:0] RECIP_M = 64'd1759218605;
    localparam int RECIP_S = 44;

    // iterative unit pacing
    localparam int SQRT_STEPS  = 4;
    localparam int SQRT_CYCLES = 8;
    localparam int DIV_STEPS   = 4;
    localparam int DIV_CYCLES  = 4;
    localparam int CNT_W       = 3;

    // queue depth between front and back
    localparam int FIFO_DEPTH = 2;

    // table generation constants
    localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
    localparam logic [63:0] ROM_DEN = 64'(2 * SINE_LAST);
    // angle step split into whole and leftover parts
    localparam logic [63:0] ROM_STEP_Q = PI_Q62 / ROM_DEN;
    localparam logic [63:0] ROM_STEP_R = PI_Q62 % ROM_DEN;
    // reciprocal of the step denominator, exact for dividends below 2^32
    localparam int          ROM_DEN_SH  = 41;
    localparam logic [63:0] ROM_DEN_INV = ((64'd1 << ROM_DEN_SH) + ROM_DEN - 64'd1) / ROM_DEN;
    // reciprocals of the taylor term divisors, exact for 64 bit dividends
    localparam int TAYLOR_SH = 74;
    localparam logic [0:12][79:0] TAYLOR_INV = {
        80'(((80'd1 << TAYLOR_SH) + 80'd5) / 80'd6),
        80'(((80'd1 << TAYLOR_SH) + 80'd19) / 80'd20),
        80'(((80'd1 << TAYLOR_SH) + 80'd41) / 80'd42),
        80'(((80'd1 << TAYLOR_SH) + 80'd71) / 80'd72),
        80'(((80'd1 << TAYLOR_SH) + 80'd109) / 80'd110),
        80'(((80'd1 << TAYLOR_SH) + 80'd155) / 80'd156),
        80'(((80'd1 << TAYLOR_SH) + 80'd209) / 80'd210),
        80'(((80'd1 << TAYLOR_SH) + 80'd271) / 80'd272),
        80'(((80'd1 << TAYLOR_SH) + 80'd341) / 80'd342),
        80'(((80'd1 << TAYLOR_SH) + 80'd419) / 80'd420),
        80'(((80'd1 << TAYLOR_SH) + 80'd505) / 80'd506),
        80'(((80'd1 << TAYLOR_SH) + 80'd599) / 80'd600),
        80'(((80'd1 << TAYLOR_SH) + 80'd701) / 80'd702)
    };

    // register map
    typedef enum logic [0:0] {
        REG_SUPPLY = 1'b0,
        REG_PERIOD = 1'b1
    } t_reg_index;

    // back end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SUM,
        ST_SQUARE,
        ST_ACCUM,
        ST_SQRT,
        ST_DIV_PREP,
        ST_DIV,
        ST_TIME_MUL,
        ST_TIME_SCALE,
        ST_TIME_DIV,
        ST_DUTY,
        ST_COMPARE
    } t_back_state;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [VOLT_W-1:0] volt_q;
        logic signed [VOLT_W-1:0] volt_d;
        logic signed [SINE_W:0]   sin_e;
        logic signed [SINE_W:0]   cos_e;
        logic [SINE_W-1:0]        sin_t1;
        logic [SINE_W-1:0]        sin_t2;
        logic [SECTOR_W-1:0]      sector;
    } t_item;

    typedef logic [SINE_W-1:0] t_sine_rom [SINE_N];

    // (a * b) >> 62 with a full width product
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // quarter-wave sine table by fixed point taylor series
    function automatic t_sine_rom build_rom();
        t_sine_rom    rom;
        logic [63:0]  x;
        logic [63:0]  x2;
        logic [63:0]  term;
        logic [63:0]  s;
        logic [63:0]  v;
        logic [63:0]  fr;
        logic [191:0] wide;
        for (int i = 0; i < SINE_N; i++) begin
            fr = ROM_STEP_R * 64'(i);
            x = ROM_STEP_Q * 64'(i) + ((fr * ROM_DEN_INV) >> ROM_DEN_SH);
            x2 = mul_q62(x, x);
            term = x;
            s = x;
            for (int k = 1; k <= 13; k++) begin
                wide = 192'(mul_q62(term, x2)) * 192'(TAYLOR_INV[k-1]);
                term = wide[TAYLOR_SH+63:TAYLOR_SH];
                if ((k & 1) == 1) s = s - term;
                else s = s + term;
            end
            v = (mul_q62(s, 64'(2 * SINE_SCALE)) + 64'd1) >> 1;
            rom[i] = (v > 64'(SINE_SCALE)) ? SINE_W'(SINE_SCALE) : v[SINE_W-1:0];
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = build_rom();

    // signed sine of a full-turn angle
    function automatic logic signed [SINE_W:0] turn_sine(input logic [ANGLE_W-1:0] a);
        logic [1:0]                       q;
        logic [ANGLE_W-3:0]               p;
        logic [ANGLE_W+SINE_IDX_W-3:0]    prod;
        logic [SINE_IDX_W-1:0]            k;
        logic signed [SINE_W:0]           v;
        q = a[ANGLE_W-1:ANGLE_W-2];
        p = a[ANGLE_W-3:0];
        prod = (ANGLE_W+SINE_IDX_W-2)'(p) * (ANGLE_W+SINE_IDX_W-2)'(SINE_LAST)
             + (ANGLE_W+SINE_IDX_W-2)'(QUARTER / 2);
        k = prod[ANGLE_W+SINE_IDX_W-3:ANGLE_W-2];
        if (q[0]) k = SINE_IDX_W'(SINE_LAST) - k;
        if (k > SINE_IDX_W'(SINE_LAST)) k = SINE_IDX_W'(SINE_LAST);
        v = $signed({1'b0, SINE_ROM[k]});
        return q[1] ? -v : v;
    endfunction

    // table index for an active vector time, num in 0..TURN
    function automatic logic [SINE_IDX_W-1:0] time_index(input logic [ANGLE_W:0] num);
        logic [ANGLE_W+10:0]   acc;
        logic [9:0]            y;
        logic [19:0]           yq;
        logic [SINE_IDX_W-1:0] k;
        acc = (ANGLE_W+11)'(num) * (ANGLE_W+11)'(4 * SINE_LAST) + (ANGLE_W+11)'(3 * TURN);
        y = acc[ANGLE_W+10:ANGLE_W+1];
        // divide by three, exact below 1536
        yq = 20'(y) * 20'd683;
        k = yq[18:11];
        if (k > SINE_IDX_W'(SINE_LAST)) k = SINE_IDX_W'(SINE_LAST);
        return k;
    endfunction

endpackage

FILE: hdl/svpwm_fifo.sv
// two entry queue between the front classifier and the back sequencer
module svpwm_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_not_full,
    input  svpwm_pkg::t_item  i_data,
    input  logic              i_pop,
    output logic              o_not_empty,
    output svpwm_pkg::t_item  o_data
);
    import svpwm_pkg::*;

    t_item      r_mem [FIFO_DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_not_full  = (r_count != 2'(FIFO_DEPTH));
    assign o_not_empty = (r_count != 2'd0);
    assign o_data      = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_not_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) r_wr_ptr <= ~r_wr_ptr;
            if (do_pop) r_rd_ptr <= ~r_rd_ptr;
            if (do_push && !do_pop) r_count <= r_count + 2'd1;
            else if (do_pop && !do_push) r_count <= r_count - 2'd1;
        end
    end

endmodule

FILE: hdl/svpwm_front.sv
// front end: takes a transaction, looks up sines and classifies the sector
module svpwm_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [svpwm_pkg::VOLT_W-1:0]   i_volt_q,
    input  logic signed [svpwm_pkg::VOLT_W-1:0]   i_volt_d,
    input  logic [svpwm_pkg::ANGLE_W-1:0]         i_elec_angle,
    output logic                                  o_item_valid,
    input  logic                                  i_item_ready,
    output svpwm_pkg::t_item                      o_item
);
    import svpwm_pkg::*;

    logic                  r_valid;
    t_item                 r_item;
    t_item                 n_item;
    logic [ANGLE_W-1:0]    ang_next;
    logic [ANGLE_W-1:0]    ang_prev;
    logic [ANGLE_W-1:0]    ref_ang;
    logic [ANGLE_W+2:0]    prod6;
    logic [ANGLE_W-1:0]    frac;
    logic                  accept;

    assign o_ready      = !r_valid || i_item_ready;
    assign accept       = i_valid && o_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    // rotate angles, sector split and table lookups
    always_comb begin
        ang_next = i_elec_angle + ANGLE_W'(QUARTER);
        ang_prev = i_elec_angle - ANGLE_W'(QUARTER);
        ref_ang  = (i_volt_q > 0) ? ang_next : ang_prev;
        prod6    = (ANGLE_W+3)'(ref_ang) * (ANGLE_W+3)'(6);
        frac     = prod6[ANGLE_W-1:0];
        n_item.volt_q = i_volt_q;
        n_item.volt_d = i_volt_d;
        n_item.sin_e  = turn_sine(i_elec_angle);
        n_item.cos_e  = turn_sine(ang_next);
        n_item.sin_t1 = SINE_ROM[time_index((ANGLE_W+1)'(TURN) - (ANGLE_W+1)'(frac))];
        n_item.sin_t2 = SINE_ROM[time_index((ANGLE_W+1)'(frac))];
        n_item.sector = prod6[ANGLE_W+2:ANGLE_W];
    end

    // output stage towards the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_item_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_item <= n_item;
    end

endmodule

FILE: hdl/svpwm_back.sv
// back end: inverse park, magnitude, modulation index, times and compares
module svpwm_back (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_item_valid,
    output logic                                   o_item_ready,
    input  svpwm_pkg::t_item                       i_item,
    input  logic [svpwm_pkg::SUPPLY_W-1:0]         i_supply,
    input  logic [svpwm_pkg::PERIOD_W-1:0]         i_period,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [svpwm_pkg::COMPARE_W-1:0]        o_compare_a,
    output logic [svpwm_pkg::COMPARE_W-1:0]        o_compare_b,
    output logic [svpwm_pkg::COMPARE_W-1:0]        o_compare_c,
    output logic [svpwm_pkg::SECTOR_W-1:0]         o_sector_index
);
    import svpwm_pkg::*;

    t_back_state        r_state;
    t_back_state        n_state;
    t_item              r_item;
    logic [CNT_W-1:0]   r_cnt;

    logic signed [30:0] r_p_dc;
    logic signed [30:0] r_p_qs;
    logic signed [30:0] r_p_ds;
    logic signed [30:0] r_p_qc;
    logic signed [31:0] r_alpha;
    logic signed [31:0] r_beta;
    logic [59:0]        r_sq_a;
    logic [59:0]        r_sq_b;
    logic [63:0]        r_rad;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [28:0]        r_den;
    logic               r_sat;
    logic [29:0]        r_drem;
    logic [UREF_W-1:0]  r_quot;
    logic [29:0]        r_m1;
    logic [29:0]        r_m2;
    logic [46:0]        r_x1;
    logic [46:0]        r_x2;
    logic [TIME_W-1:0]  r_t1;
    logic [TIME_W-1:0]  r_t2;
    logic [DUTY_W-1:0]  r_duty_a;
    logic [DUTY_W-1:0]  r_duty_b;
    logic [DUTY_W-1:0]  r_duty_c;
    logic               r_out_valid;
    logic [COMPARE_W-1:0] r_cmp_a;
    logic [COMPARE_W-1:0] r_cmp_b;
    logic [COMPARE_W-1:0] r_cmp_c;
    logic [SECTOR_W-1:0]  r_sector;

    logic               item_pop;
    logic               out_load;
    logic               out_free;
    logic signed [63:0] sqa;
    logic signed [63:0] sqb;
    logic [33:0]        sq_rem;
    logic [31:0]        sq_root;
    logic [63:0]        sq_rad;
    logic [33:0]        sq_trial;
    logic [29:0]        dv_rem;
    logic [30:0]        dv_sh;
    logic [UREF_W-1:0]  dv_q;
    logic [UREF_W-1:0]  uref;
    logic [SUPPLY_W-1:0] volts;
    logic [61:0]        td1;
    logic [61:0]        td2;
    logic [TIME_W:0]    tsum;
    logic [TIME_W-1:0]  t0;
    logic [TIME_W-1:0]  half;
    logic [TIME_W+1:0]  d_a;
    logic [TIME_W+1:0]  d_b;
    logic [TIME_W+1:0]  d_c;
    logic [TIME_W+1:0]  d_full;
    logic [TIME_W+1:0]  d_t1h;
    logic [TIME_W+1:0]  d_t2h;
    logic [TIME_W+1:0]  d_h;
    logic [DUTY_W+PERIOD_W-1:0] sc_a;
    logic [DUTY_W+PERIOD_W-1:0] sc_b;
    logic [DUTY_W+PERIOD_W-1:0] sc_c;

    assign out_free       = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_compare_a    = r_cmp_a;
    assign o_compare_b    = r_cmp_b;
    assign o_compare_c    = r_cmp_c;
    assign o_sector_index = r_sector;
    assign o_item_ready   = item_pop;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:       if (i_item_valid) n_state = ST_ROTATE;
            ST_ROTATE:     n_state = ST_SUM;
            ST_SUM:        n_state = ST_SQUARE;
            ST_SQUARE:     n_state = ST_ACCUM;
            ST_ACCUM:      n_state = ST_SQRT;
            ST_SQRT:       if (r_cnt == CNT_W'(SQRT_CYCLES - 1)) n_state = ST_DIV_PREP;
            ST_DIV_PREP:   n_state = ST_DIV;
            ST_DIV:        if (r_cnt == CNT_W'(DIV_CYCLES - 1)) n_state = ST_TIME_MUL;
            ST_TIME_MUL:   n_state = ST_TIME_SCALE;
            ST_TIME_SCALE: n_state = ST_TIME_DIV;
            ST_TIME_DIV:   n_state = ST_DUTY;
            ST_DUTY:       n_state = ST_COMPARE;
            ST_COMPARE:    if (out_free) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        item_pop = (r_state == ST_IDLE);
        out_load = (r_state == ST_COMPARE) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // squares of the rotated components
    always_comb begin
        sqa = 64'(r_alpha) * 64'(r_alpha);
        sqb = 64'(r_beta) * 64'(r_beta);
    end

    // square root, several result bits per cycle
    always_comb begin
        sq_rem  = r_rem;
        sq_root = r_root;
        sq_rad  = r_rad;
        sq_trial = '0;
        for (int i = 0; i < SQRT_STEPS; i++) begin
            sq_rem   = {sq_rem[31:0], sq_rad[63:62]};
            sq_rad   = {sq_rad[61:0], 2'b00};
            sq_trial = {sq_root, 2'b01};
            if (sq_rem >= sq_trial) begin
                sq_rem  = sq_rem - sq_trial;
                sq_root = {sq_root[30:0], 1'b1};
            end else begin
                sq_root = {sq_root[30:0], 1'b0};
            end
        end
    end

    // restoring division of magnitude by scaled supply
    always_comb begin
        dv_rem = r_drem;
        dv_q   = r_quot;
        dv_sh  = '0;
        for (int i = 0; i < DIV_STEPS; i++) begin
            dv_sh = {dv_rem, 1'b0};
            if (dv_sh >= 31'(r_den)) begin
                dv_rem = 30'(dv_sh - 31'(r_den));
                dv_q   = {dv_q[UREF_W-2:0], 1'b1};
            end else begin
                dv_rem = dv_sh[29:0];
                dv_q   = {dv_q[UREF_W-2:0], 1'b0};
            end
        end
    end

    // clamped modulation index and supply guard
    always_comb begin
        volts = (i_supply == '0) ? SUPPLY_W'(1) : i_supply;
        if (r_sat || r_quot > UREF_W'(UREF_LIMIT)) uref = UREF_W'(UREF_LIMIT);
        else uref = r_quot;
    end

    // divide by 10000 through the reciprocal
    always_comb begin
        td1 = 62'(r_x1[46:16]) * 62'(RECIP_M);
        td2 = 62'(r_x2[46:16]) * 62'(RECIP_M);
    end

    // zero vector time and sector mapping
    always_comb begin
        tsum   = (TIME_W+1)'(r_t1) + (TIME_W+1)'(r_t2);
        t0     = (tsum >= (TIME_W+1)'(TURN)) ? '0 : TIME_W'((TIME_W+1)'(TURN) - tsum);
        half   = t0 >> 1;
        d_h    = (TIME_W+2)'(half);
        d_full = (TIME_W+2)'(tsum) + d_h;
        d_t1h  = (TIME_W+2)'(r_t1) + d_h;
        d_t2h  = (TIME_W+2)'(r_t2) + d_h;
        unique case (r_item.sector)
            3'd0: begin d_a = d_full; d_b = d_t2h;  d_c = d_h;    end
            3'd1: begin d_a = d_t1h;  d_b = d_full; d_c = d_h;    end
            3'd2: begin d_a = d_h;    d_b = d_full; d_c = d_t2h;  end
            3'd3: begin d_a = d_h;    d_b = d_t1h;  d_c = d_full; end
            3'd4: begin d_a = d_t2h;  d_b = d_h;    d_c = d_full; end
            default: begin d_a = d_full; d_b = d_h; d_c = d_t1h; end
        endcase
    end

    // duty to timer counts
    always_comb begin
        sc_a = (DUTY_W+PERIOD_W)'(r_duty_a) * (DUTY_W+PERIOD_W)'(i_period);
        sc_b = (DUTY_W+PERIOD_W)'(r_duty_b) * (DUTY_W+PERIOD_W)'(i_period);
        sc_c = (DUTY_W+PERIOD_W)'(r_duty_c) * (DUTY_W+PERIOD_W)'(i_period);
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_item_valid) r_item <= i_item;
            end
            ST_ROTATE: begin
                r_p_dc <= r_item.volt_d * r_item.cos_e;
                r_p_qs <= r_item.volt_q * r_item.sin_e;
                r_p_ds <= r_item.volt_d * r_item.sin_e;
                r_p_qc <= r_item.volt_q * r_item.cos_e;
            end
            ST_SUM: begin
                r_alpha <= 32'(r_p_dc) - 32'(r_p_qs);
                r_beta  <= 32'(r_p_ds) + 32'(r_p_qc);
            end
            ST_SQUARE: begin
                r_sq_a <= sqa[59:0];
                r_sq_b <= sqb[59:0];
            end
            ST_ACCUM: begin
                r_rad  <= 64'(r_sq_a) + 64'(r_sq_b);
                r_rem  <= '0;
                r_root <= '0;
                r_den  <= 29'(29'(SINE_SCALE) * 29'(volts));
            end
            ST_SQRT: begin
                r_rad  <= sq_rad;
                r_rem  <= sq_rem;
                r_root <= sq_root;
            end
            ST_DIV_PREP: begin
                r_sat  <= (r_root >= 32'(r_den));
                r_drem <= r_root[29:0];
                r_quot <= '0;
            end
            ST_DIV: begin
                r_drem <= dv_rem;
                r_quot <= dv_q;
            end
            ST_TIME_MUL: begin
                r_m1 <= 30'(r_item.sin_t1) * 30'(uref);
                r_m2 <= 30'(r_item.sin_t2) * 30'(uref);
            end
            ST_TIME_SCALE: begin
                r_x1 <= 47'(r_m1) * 47'(SQRT3_Q16);
                r_x2 <= 47'(r_m2) * 47'(SQRT3_Q16);
            end
            ST_TIME_DIV: begin
                r_t1 <= td1[RECIP_S+TIME_W-1:RECIP_S];
                r_t2 <= td2[RECIP_S+TIME_W-1:RECIP_S];
            end
            ST_DUTY: begin
                r_duty_a <= (d_a > (TIME_W+2)'(TURN)) ? DUTY_W'(TURN) : d_a[DUTY_W-1:0];
                r_duty_b <= (d_b > (TIME_W+2)'(TURN)) ? DUTY_W'(TURN) : d_b[DUTY_W-1:0];
                r_duty_c <= (d_c > (TIME_W+2)'(TURN)) ? DUTY_W'(TURN) : d_c[DUTY_W-1:0];
            end
            default: begin
            end
        endcase
    end

    // iteration counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cnt <= '0;
        else if (r_state == ST_ACCUM || r_state == ST_DIV_PREP) r_cnt <= '0;
        else if (r_state == ST_SQRT || r_state == ST_DIV) r_cnt <= r_cnt + CNT_W'(1);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_cmp_a  <= sc_a[PERIOD_W+COMPARE_W-1:PERIOD_W];
            r_cmp_b  <= sc_b[PERIOD_W+COMPARE_W-1:PERIOD_W];
            r_cmp_c  <= sc_c[PERIOD_W+COMPARE_W-1:PERIOD_W];
            r_sector <= r_item.sector;
        end
    end

endmodule

FILE: hdl/svpwm_duty_from_dq_voltage.sv
// top level: space vector pwm compare values from d/q voltage commands
//
//  channel   handshake          payload
//  input     i_valid/o_ready    i_volt_q, i_volt_d, i_elec_angle
//  output    o_valid/i_ready    o_compare_a/b/c, o_sector_index
//  config    psel/penable/...   paddr 0 supply voltage, 4 timer period
//
// the back sequencer works through one transaction at a time; the square
// root and the division, which each find four result bits per iteration, set
// most of its time. the front and a two entry queue take new transactions while
// the back is busy; a finished result waits in the output register.
// synchronous reset clears control state and loads the register defaults.
module svpwm_duty_from_dq_voltage (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [svpwm_pkg::VOLT_W-1:0]      i_volt_q,
    input  logic signed [svpwm_pkg::VOLT_W-1:0]      i_volt_d,
    input  logic [svpwm_pkg::ANGLE_W-1:0]            i_elec_angle,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [svpwm_pkg::COMPARE_W-1:0]          o_compare_a,
    output logic [svpwm_pkg::COMPARE_W-1:0]          o_compare_b,
    output logic [svpwm_pkg::COMPARE_W-1:0]          o_compare_c,
    output logic [svpwm_pkg::SECTOR_W-1:0]           o_sector_index,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [svpwm_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [svpwm_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [svpwm_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                     pready
);
    import svpwm_pkg::*;

    logic [SUPPLY_W-1:0] r_supply;
    logic [PERIOD_W-1:0] r_period;
    t_reg_index          reg_sel;
    logic                cfg_write;

    logic  fr_valid;
    logic  fr_ready;
    t_item fr_item;
    logic  q_valid;
    logic  q_pop;
    t_item q_item;

    assign pready    = 1'b1;
    assign reg_sel   = t_reg_index'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_supply <= SUPPLY_W'(6144);
            r_period <= PERIOD_W'(1200);
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_SUPPLY: r_supply <= pwdata[SUPPLY_W-1:0];
                REG_PERIOD: r_period <= pwdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // register read back
    always_comb begin
        unique case (reg_sel)
            REG_SUPPLY: prdata = APB_DATA_W'(r_supply);
            REG_PERIOD: prdata = APB_DATA_W'(r_period);
            default:    prdata = '0;
        endcase
    end

    svpwm_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_volt_q     (i_volt_q),
        .i_volt_d     (i_volt_d),
        .i_elec_angle (i_elec_angle),
        .o_item_valid (fr_valid),
        .i_item_ready (fr_ready),
        .o_item       (fr_item)
    );

    svpwm_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (fr_valid),
        .o_not_full  (fr_ready),
        .i_data      (fr_item),
        .i_pop       (q_pop),
        .o_not_empty (q_valid),
        .o_data      (q_item)
    );

    svpwm_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (q_valid),
        .o_item_ready   (q_pop),
        .i_item         (q_item),
        .i_supply       (r_supply),
        .i_period       (r_period),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_compare_a    (o_compare_a),
        .o_compare_b    (o_compare_b),
        .o_compare_c    (o_compare_c),
        .o_sector_index (o_sector_index)
    );

endmodule
